>>> hw/rtl/adam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam update package
// Shared widths, constants, register indexes, sideband types and helpers.
// ----------------------------------------------------------------------------
package adam_pkg;

    localparam int DATA_W = 32;

    // One in Q0.32, as a 33-bit value.
    localparam logic [32:0] Q_ONE = 33'h1_0000_0000;

    // Register reset values.
    localparam logic [31:0] LR_RESET    = 32'd4294967;
    localparam logic [31:0] BETA1_RESET = 32'd3865470566;
    localparam logic [31:0] BETA2_RESET = 32'd4290672329;
    localparam logic [31:0] EPS_RESET   = 32'd43;
    localparam logic [31:0] DECAY_RESET = 32'd0;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_LEARNING_RATE = 3'd0,
        CFG_BETA_FIRST    = 3'd1,
        CFG_BETA_SECOND   = 3'd2,
        CFG_EPSILON       = 3'd3,
        CFG_DECAY_RATE    = 3'd4,
        CFG_DECAY_MODE    = 3'd5
    } cfg_reg_t;

    // Input word kinds.
    localparam logic ACT_BEGIN_STEP = 1'b0;
    localparam logic ACT_ELEMENT    = 1'b1;

    // Decay modes.
    localparam logic DECAY_COUPLED   = 1'b0;
    localparam logic DECAY_DECOUPLED = 1'b1;

    // First divider: corrected second moment, (v * 2^32) / c2.
    localparam int DIV1_DEN_W = 33;
    localparam int DIV1_Q_W   = 64;

    // Square root unit.
    localparam int SQRT_X_W    = 64;
    localparam int SQRT_ROOT_W = 32;
    localparam int SQRT_REM_W  = 36;

    // Second divider: step size, (lr * |m| * 2^32) / (c1 * d).
    localparam int DIV2_DEN_W = 86;
    localparam int DIV2_Q_W   = 34;

    // Configuration seen by the moment stages.
    typedef struct packed {
        logic [31:0] beta_first;
        logic [31:0] beta_second;
        logic [31:0] decay_rate;
        logic [31:0] decay_factor;
        logic        decay_mode;
    } mom_cfg_t;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] m;
        logic [31:0]        v;
        logic [32:0]        c1;
    } div1_side_t;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] m;
        logic [31:0]        v;
        logic [32:0]        c1;
        logic [4:0]         half;
    } sqrt_side_t;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] m;
        logic [31:0]        v;
        logic               ovf;
    } div2_side_t;

    localparam int DIV1_SIDE_W = $bits(div1_side_t);
    localparam int SQRT_SIDE_W = $bits(sqrt_side_t);
    localparam int DIV2_SIDE_W = $bits(div2_side_t);

    // Saturate a signed value to 32 bits.
    function automatic logic signed [31:0] sat_s32(input logic signed [35:0] x);
        logic signed [31:0] res;
        begin
            if (x > 36'sd2147483647)
                res = 32'sh7FFF_FFFF;
            else if (x < -36'sd2147483648)
                res = 32'sh8000_0000;
            else
                res = x[31:0];
            return res;
        end
    endfunction

endpackage

>>> hw/rtl/adam_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam pipelined divider
// Restoring division, one quotient bit per register stage, with sideband.
// ----------------------------------------------------------------------------
module adam_div_pipe #(
    parameter int DEN_W  = adam_pkg::DIV1_DEN_W,
    parameter int Q_W    = adam_pkg::DIV1_Q_W,
    parameter int SIDE_W = adam_pkg::DIV1_SIDE_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [Q_W-1:0]    in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg [Q_W];
    logic [DEN_W-1:0]  rem_reg   [Q_W];
    logic [Q_W-1:0]    nq_reg    [Q_W];
    logic [DEN_W-1:0]  den_reg   [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];

    logic              src_valid [Q_W];
    logic [DEN_W-1:0]  src_rem   [Q_W];
    logic [Q_W-1:0]    src_nq    [Q_W];
    logic [DEN_W-1:0]  src_den   [Q_W];
    logic [SIDE_W-1:0] src_side  [Q_W];

    logic [DEN_W-1:0]  rem_next  [Q_W];
    logic [Q_W-1:0]    nq_next   [Q_W];

    always_comb
    begin
        src_valid[0] = in_valid;
        src_rem[0]   = in_rem;
        src_nq[0]    = in_num;
        src_den[0]   = in_den;
        src_side[0]  = in_side;
        for (int j = 1; j < Q_W; j++)
        begin
            src_valid[j] = valid_reg[j-1];
            src_rem[j]   = rem_reg[j-1];
            src_nq[j]    = nq_reg[j-1];
            src_den[j]   = den_reg[j-1];
            src_side[j]  = side_reg[j-1];
        end
    end

    // The numerator shifts out at the top while quotient bits shift in below.
    always_comb
    begin : step
        logic [DEN_W:0] shifted;
        for (int j = 0; j < Q_W; j++)
        begin
            shifted = {src_rem[j], src_nq[j][Q_W-1]};
            if (shifted >= {1'b0, src_den[j]})
            begin
                rem_next[j] = DEN_W'(shifted - {1'b0, src_den[j]});
                nq_next[j]  = {src_nq[j][Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = shifted[DEN_W-1:0];
                nq_next[j]  = {src_nq[j][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < Q_W; j++)
                valid_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            for (int j = 0; j < Q_W; j++)
                valid_reg[j] <= src_valid[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < Q_W; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                nq_reg[j]   <= nq_next[j];
                den_reg[j]  <= src_den[j];
                side_reg[j] <= src_side[j];
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_quot  = nq_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

>>> hw/rtl/adam_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam pipelined square root
// Integer floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module adam_sqrt_pipe #(
    parameter int SIDE_W = adam_pkg::SQRT_SIDE_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [adam_pkg::SQRT_X_W-1:0]    in_x,
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic [adam_pkg::SQRT_ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0]                out_side
);

    localparam int NS = adam_pkg::SQRT_ROOT_W;
    localparam int XW = adam_pkg::SQRT_X_W;
    localparam int RW = adam_pkg::SQRT_REM_W;

    logic              valid_reg [NS];
    logic [XW-1:0]     x_reg     [NS];
    logic [NS-1:0]     root_reg  [NS];
    logic [RW-1:0]     rem_reg   [NS];
    logic [SIDE_W-1:0] side_reg  [NS];

    logic              src_valid [NS];
    logic [XW-1:0]     src_x     [NS];
    logic [NS-1:0]     src_root  [NS];
    logic [RW-1:0]     src_rem   [NS];
    logic [SIDE_W-1:0] src_side  [NS];

    logic [NS-1:0]     root_next [NS];
    logic [RW-1:0]     rem_next  [NS];

    always_comb
    begin
        src_valid[0] = in_valid;
        src_x[0]     = in_x;
        src_root[0]  = '0;
        src_rem[0]   = '0;
        src_side[0]  = in_side;
        for (int j = 1; j < NS; j++)
        begin
            src_valid[j] = valid_reg[j-1];
            src_x[j]     = x_reg[j-1];
            src_root[j]  = root_reg[j-1];
            src_rem[j]   = rem_reg[j-1];
            src_side[j]  = side_reg[j-1];
        end
    end

    // Bring down two radicand bits and try the next root bit.
    always_comb
    begin : step
        logic [RW-1:0] shifted;
        logic [RW-1:0] trial;
        for (int j = 0; j < NS; j++)
        begin
            shifted = {src_rem[j][RW-3:0], src_x[j][XW-1:XW-2]};
            trial   = RW'({src_root[j], 2'b01});
            if (shifted >= trial)
            begin
                rem_next[j]  = shifted - trial;
                root_next[j] = {src_root[j][NS-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = shifted;
                root_next[j] = {src_root[j][NS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NS; j++)
                valid_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            for (int j = 0; j < NS; j++)
                valid_reg[j] <= src_valid[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NS; j++)
            begin
                x_reg[j]    <= {src_x[j][XW-3:0], 2'b00};
                root_reg[j] <= root_next[j];
                rem_reg[j]  <= rem_next[j];
                side_reg[j] <= src_side[j];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

>>> hw/rtl/adam_moment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adam moment stages
// Weight decay, then the new first and second moments, in five stages.
// ----------------------------------------------------------------------------
module adam_moment (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  adam_pkg::mom_cfg_t cfg,
    input  logic               in_valid,
    input  logic signed [31:0] in_w,
    input  logic signed [31:0] in_g,
    input  logic signed [31:0] in_m0,
    input  logic [31:0]        in_v0,
    input  logic [32:0]        in_c1,
    input  logic [32:0]        in_c2,
    output logic               out_valid,
    output logic signed [31:0] out_w,
    output logic signed [31:0] out_m,
    output logic [31:0]        out_v,
    output logic [32:0]        out_c1,
    output logic [32:0]        out_c2
);

    // Stage 1: decay.
    logic signed [32:0] dec_mul;
    logic signed [64:0] dec_prod;
    logic signed [33:0] dec_sum;
    logic signed [31:0] w1_next;
    logic signed [31:0] g1_next;

    logic               s1_valid_reg;
    logic signed [31:0] s1_w_reg;
    logic signed [31:0] s1_g_reg;
    logic signed [31:0] s1_m0_reg;
    logic [31:0]        s1_v0_reg;
    logic [32:0]        s1_c1_reg;
    logic [32:0]        s1_c2_reg;

    // The decayed values get their own register between stage 1 and 2.
    logic signed [31:0] s1g_dec_reg;
    logic signed [31:0] s1w_dec_reg;
    logic               s1d_valid_reg;
    logic signed [31:0] s1d_m0_reg;
    logic [31:0]        s1d_v0_reg;
    logic [32:0]        s1d_c1_reg;
    logic [32:0]        s1d_c2_reg;

    // Stage 2: moment products.
    logic signed [32:0] b1_s;
    logic [32:0]        omb1;
    logic signed [33:0] omb1_s;
    logic signed [64:0] pm1_prod;
    logic signed [65:0] pm2_prod;
    logic [31:0]        g_abs;
    logic [63:0]        gg_prod;
    logic [63:0]        bv_prod;

    logic               s2_valid_reg;
    logic signed [31:0] s2_w_reg;
    logic signed [32:0] s2_pm1_reg;
    logic signed [33:0] s2_pm2_reg;
    logic [63:0]        s2_gg_reg;
    logic [31:0]        s2_bv_reg;
    logic [32:0]        s2_c1_reg;
    logic [32:0]        s2_c2_reg;

    // Stage 3: first moment, partial products of the second.
    logic signed [34:0] m_sum;
    logic [32:0]        omb2;

    logic               s3_valid_reg;
    logic signed [31:0] s3_w_reg;
    logic signed [31:0] s3_m_reg;
    logic [64:0]        s3_pvlo_reg;
    logic [64:0]        s3_pvhi_reg;
    logic [31:0]        s3_bv_reg;
    logic [32:0]        s3_c1_reg;
    logic [32:0]        s3_c2_reg;

    // Stage 4: second moment.
    logic [96:0]        pv_sum;
    logic [41:0]        v_sum;
    logic [31:0]        v_next;

    logic               s4_valid_reg;
    logic signed [31:0] s4_w_reg;
    logic signed [31:0] s4_m_reg;
    logic [31:0]        s4_v_reg;
    logic [32:0]        s4_c1_reg;
    logic [32:0]        s4_c2_reg;

    // One multiplier serves both modes: coupled decay scales the weight by
    // the decay rate, decoupled decay by the learning rate times decay rate.
    always_comb
    begin
        if (cfg.decay_mode == adam_pkg::DECAY_DECOUPLED)
            dec_mul = $signed({1'b0, cfg.decay_factor});
        else
            dec_mul = $signed({1'b0, cfg.decay_rate});
        dec_prod = s1_w_reg * dec_mul;
        if (cfg.decay_mode == adam_pkg::DECAY_DECOUPLED)
        begin
            dec_sum = s1_w_reg - $signed(dec_prod[64:32]);
            w1_next = adam_pkg::sat_s32(36'(dec_sum));
            g1_next = s1_g_reg;
        end
        else
        begin
            dec_sum = s1_g_reg + $signed(dec_prod[64:32]);
            w1_next = s1_w_reg;
            g1_next = adam_pkg::sat_s32(36'(dec_sum));
        end
    end

    always_comb
    begin
        b1_s     = $signed({1'b0, cfg.beta_first});
        omb1     = adam_pkg::Q_ONE - {1'b0, cfg.beta_first};
        omb1_s   = $signed({1'b0, omb1});
        pm1_prod = b1_s * s1d_m0_reg;
        pm2_prod = omb1_s * s1g_dec_reg;
        g_abs    = s1g_dec_reg[31] ? (~s1g_dec_reg + 32'd1) : s1g_dec_reg;
        gg_prod  = 64'(g_abs) * 64'(g_abs);
        bv_prod  = 64'(cfg.beta_second) * 64'(s1d_v0_reg);
    end

    always_comb
    begin
        m_sum  = 35'(s2_pm1_reg) + 35'(s2_pm2_reg);
        omb2   = adam_pkg::Q_ONE - {1'b0, cfg.beta_second};
        pv_sum = {s3_pvhi_reg, 32'h0} + 97'(s3_pvlo_reg);
        v_sum  = 42'(s3_bv_reg) + 42'(pv_sum[96:56]);
        v_next = (|v_sum[41:32]) ? 32'hFFFF_FFFF : v_sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1d_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s1d_valid_reg <= s1_valid_reg;
            s2_valid_reg  <= s1d_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_w_reg    <= in_w;
            s1_g_reg    <= in_g;
            s1_m0_reg   <= in_m0;
            s1_v0_reg   <= in_v0;
            s1_c1_reg   <= in_c1;
            s1_c2_reg   <= in_c2;

            s1w_dec_reg <= w1_next;
            s1g_dec_reg <= g1_next;
            s1d_m0_reg  <= s1_m0_reg;
            s1d_v0_reg  <= s1_v0_reg;
            s1d_c1_reg  <= s1_c1_reg;
            s1d_c2_reg  <= s1_c2_reg;

            s2_w_reg    <= s1w_dec_reg;
            s2_pm1_reg  <= pm1_prod[64:32];
            s2_pm2_reg  <= pm2_prod[65:32];
            s2_gg_reg   <= gg_prod;
            s2_bv_reg   <= bv_prod[63:32];
            s2_c1_reg   <= s1d_c1_reg;
            s2_c2_reg   <= s1d_c2_reg;

            s3_w_reg    <= s2_w_reg;
            s3_m_reg    <= adam_pkg::sat_s32(36'(m_sum));
            s3_pvlo_reg <= 65'(omb2) * 65'(s2_gg_reg[31:0]);
            s3_pvhi_reg <= 65'(omb2) * 65'(s2_gg_reg[63:32]);
            s3_bv_reg   <= s2_bv_reg;
            s3_c1_reg   <= s2_c1_reg;
            s3_c2_reg   <= s2_c2_reg;

            s4_w_reg    <= s3_w_reg;
            s4_m_reg    <= s3_m_reg;
            s4_v_reg    <= v_next;
            s4_c1_reg   <= s3_c1_reg;
            s4_c2_reg   <= s3_c2_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_w     = s4_w_reg;
    assign out_m     = s4_m_reg;
    assign out_v     = s4_v_reg;
    assign out_c1    = s4_c1_reg;
    assign out_c2    = s4_c2_reg;

endmodule

>>> hw/rtl/adam_param_update.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle while m_axis_tready is high or the output register is
// empty; every stage is a register, and the two dividers and the square root give one
// bit per stage (64, 32 and 34 stages).
// Reset: rst_n clears all valid bits, loads the register defaults and sets both beta
// powers to all ones; no clearing pass, words are taken from the first cycle.
// ----------------------------------------------------------------------------
// Adam parameter update
// Streaming element-wise Adam / AdamW update in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module adam_param_update (
    input  logic         clk,
    input  logic         rst_n,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: weight[31:0], gradient[63:32], moment_first[95:64],
    // moment_second[127:96].
    input  logic [127:0] s_axis_tdata,
    // tuser from bit 0: action.
    input  logic [0:0]   s_axis_tuser,
    // Result stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: new_weight[31:0], new_moment_first[63:32],
    // new_moment_second[95:64].
    output logic [95:0]  m_axis_tdata,
    // Configuration writes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // The whole pipeline moves as one: it advances whenever the output
    // register is empty or its word is being taken. Begin-step words update
    // the powers at acceptance and never enter the pipeline.
    logic adv;
    logic accept;

    // Configuration registers.
    logic [31:0] lr_reg;
    logic [31:0] beta1_reg;
    logic [31:0] beta2_reg;
    logic [31:0] eps_reg;
    logic [31:0] decay_reg;
    logic        mode_reg;
    logic [31:0] factor_reg;
    logic [63:0] factor_prod;

    // Beta powers.
    logic [31:0] pow1_reg;
    logic [31:0] pow2_reg;
    logic [63:0] pow1_prod;
    logic [63:0] pow2_prod;

    // Entry stage.
    logic               s0_valid_reg;
    logic signed [31:0] s0_w_reg;
    logic signed [31:0] s0_g_reg;
    logic signed [31:0] s0_m0_reg;
    logic [31:0]        s0_v0_reg;
    logic [32:0]        s0_c1_reg;
    logic [32:0]        s0_c2_reg;

    adam_pkg::mom_cfg_t mom_cfg;

    logic               mom_valid;
    logic signed [31:0] mom_w;
    logic signed [31:0] mom_m;
    logic [31:0]        mom_v;
    logic [32:0]        mom_c1;
    logic [32:0]        mom_c2;

    // Corrected second moment.
    adam_pkg::div1_side_t div1_in_side;
    logic [adam_pkg::DIV1_SIDE_W-1:0] div1_out_side;
    adam_pkg::div1_side_t div1_side;
    logic        div1_valid;
    logic [63:0] div1_quot;

    // Normalization ahead of the square root.
    logic [5:0]           norm_k;
    logic                 n1_valid_reg;
    logic [63:0]          n1_r_reg;
    logic [5:0]           n1_k_reg;
    adam_pkg::div1_side_t n1_side_reg;
    logic                 n2_valid_reg;
    logic [63:0]          n2_x_reg;
    adam_pkg::sqrt_side_t n2_side_reg;

    logic [adam_pkg::SQRT_SIDE_W-1:0] sqrt_out_side;
    adam_pkg::sqrt_side_t sqrt_side;
    logic        sqrt_valid;
    logic [31:0] sqrt_root;

    // Denominator build.
    logic [51:0]        s_val;
    logic [52:0]        d_sum;
    logic [52:0]        d_val;
    logic [31:0]        m_abs;
    logic               t1_valid_reg;
    logic [52:0]        t1_d_reg;
    logic [63:0]        t1_mag_reg;
    logic [32:0]        t1_c1_reg;
    logic signed [31:0] t1_w_reg;
    logic signed [31:0] t1_m_reg;
    logic [31:0]        t1_v_reg;
    logic               t2_valid_reg;
    logic [64:0]        t2_pdlo_reg;
    logic [53:0]        t2_pdhi_reg;
    logic [63:0]        t2_mag_reg;
    logic signed [31:0] t2_w_reg;
    logic signed [31:0] t2_m_reg;
    logic [31:0]        t2_v_reg;
    logic [85:0]        den_sum;
    logic               t3_valid_reg;
    logic [85:0]        t3_den_reg;
    logic [63:0]        t3_mag_reg;
    adam_pkg::div2_side_t t3_side_reg;
    adam_pkg::div2_side_t t3_side_next;

    // Step size and result.
    logic [adam_pkg::DIV2_SIDE_W-1:0] div2_out_side;
    adam_pkg::div2_side_t div2_side;
    logic               div2_valid;
    logic [33:0]        div2_quot;
    logic [33:0]        step_u;
    logic signed [35:0] w_upd;

    logic               out_valid_reg;
    logic signed [31:0] out_w_reg;
    logic signed [31:0] out_m_reg;
    logic [31:0]        out_v_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign cfg_ready     = 1'b1;

    //------------------------------------------------------------------
    // Configuration and beta powers.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg    <= adam_pkg::LR_RESET;
            beta1_reg <= adam_pkg::BETA1_RESET;
            beta2_reg <= adam_pkg::BETA2_RESET;
            eps_reg   <= adam_pkg::EPS_RESET;
            decay_reg <= adam_pkg::DECAY_RESET;
            mode_reg  <= adam_pkg::DECAY_COUPLED;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                adam_pkg::CFG_LEARNING_RATE: lr_reg    <= cfg_data;
                adam_pkg::CFG_BETA_FIRST:    beta1_reg <= cfg_data;
                adam_pkg::CFG_BETA_SECOND:   beta2_reg <= cfg_data;
                adam_pkg::CFG_EPSILON:       eps_reg   <= cfg_data;
                adam_pkg::CFG_DECAY_RATE:    decay_reg <= cfg_data;
                adam_pkg::CFG_DECAY_MODE:    mode_reg  <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // The decoupled shrink factor is registered from lr and decay rate in the next cycle,
    // well before any element word can use it.
    assign factor_prod = 64'(lr_reg) * 64'(decay_reg);

    always_ff @(posedge clk)
    begin
        factor_reg <= factor_prod[63:32];
    end

    assign pow1_prod = 64'(pow1_reg) * 64'(beta1_reg);
    assign pow2_prod = 64'(pow2_reg) * 64'(beta2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pow1_reg <= '1;
            pow2_reg <= '1;
        end
        else if (accept && (s_axis_tuser[0] == adam_pkg::ACT_BEGIN_STEP))
        begin
            pow1_reg <= pow1_prod[63:32];
            pow2_reg <= pow2_prod[63:32];
        end
    end

    //------------------------------------------------------------------
    // Entry register. The bias corrections are taken here so that words
    // in flight keep the powers of their own step.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= accept && (s_axis_tuser[0] == adam_pkg::ACT_ELEMENT);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_w_reg  <= s_axis_tdata[31:0];
            s0_g_reg  <= s_axis_tdata[63:32];
            s0_m0_reg <= s_axis_tdata[95:64];
            s0_v0_reg <= s_axis_tdata[127:96];
            s0_c1_reg <= adam_pkg::Q_ONE - {1'b0, pow1_reg};
            s0_c2_reg <= adam_pkg::Q_ONE - {1'b0, pow2_reg};
        end
    end

    assign mom_cfg.beta_first   = beta1_reg;
    assign mom_cfg.beta_second  = beta2_reg;
    assign mom_cfg.decay_rate   = decay_reg;
    assign mom_cfg.decay_factor = factor_reg;
    assign mom_cfg.decay_mode   = mode_reg;

    adam_moment u_moment (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .cfg       (mom_cfg),
        .in_valid  (s0_valid_reg),
        .in_w      (s0_w_reg),
        .in_g      (s0_g_reg),
        .in_m0     (s0_m0_reg),
        .in_v0     (s0_v0_reg),
        .in_c1     (s0_c1_reg),
        .in_c2     (s0_c2_reg),
        .out_valid (mom_valid),
        .out_w     (mom_w),
        .out_m     (mom_m),
        .out_v     (mom_v),
        .out_c1    (mom_c1),
        .out_c2    (mom_c2)
    );

    //------------------------------------------------------------------
    // r = v * 2^32 / c2, the bias-corrected second moment in Q40.24.
    //------------------------------------------------------------------
    assign div1_in_side.w  = mom_w;
    assign div1_in_side.m  = mom_m;
    assign div1_in_side.v  = mom_v;
    assign div1_in_side.c1 = mom_c1;

    adam_div_pipe #(
        .DEN_W  (adam_pkg::DIV1_DEN_W),
        .Q_W    (adam_pkg::DIV1_Q_W),
        .SIDE_W (adam_pkg::DIV1_SIDE_W)
    ) u_div_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (mom_valid),
        .in_rem    ('0),
        .in_num    ({mom_v, 32'h0}),
        .in_den    (mom_c2),
        .in_side   (div1_in_side),
        .out_valid (div1_valid),
        .out_quot  (div1_quot),
        .out_side  (div1_out_side)
    );

    assign div1_side = div1_out_side;

    //------------------------------------------------------------------
    // Normalize r by the largest even shift up to 40 that keeps it in 64
    // bits; the root is shifted back by half of what is left.
    //------------------------------------------------------------------
    always_comb
    begin
        norm_k = '0;
        for (int j = 1; j <= 20; j++)
        begin
            if ((div1_quot >> (64 - 2 * j)) == 64'h0)
                norm_k = 6'(2 * j);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_valid_reg <= 1'b0;
            n2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            n1_valid_reg <= div1_valid;
            n2_valid_reg <= n1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_r_reg         <= div1_quot;
            n1_k_reg         <= norm_k;
            n1_side_reg      <= div1_side;
            n2_x_reg         <= n1_r_reg << n1_k_reg;
            n2_side_reg.w    <= n1_side_reg.w;
            n2_side_reg.m    <= n1_side_reg.m;
            n2_side_reg.v    <= n1_side_reg.v;
            n2_side_reg.c1   <= n1_side_reg.c1;
            n2_side_reg.half <= 5'd20 - 5'(n1_k_reg[5:1]);
        end
    end

    adam_sqrt_pipe #(
        .SIDE_W (adam_pkg::SQRT_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (n2_valid_reg),
        .in_x      (n2_x_reg),
        .in_side   (n2_side_reg),
        .out_valid (sqrt_valid),
        .out_root  (sqrt_root),
        .out_side  (sqrt_out_side)
    );

    assign sqrt_side = sqrt_out_side;

    //------------------------------------------------------------------
    // d = sqrt + epsilon (one LSB when zero), then c1 * d in two partial
    // products, and the overflow test for the capped step size.
    //------------------------------------------------------------------
    always_comb
    begin
        s_val = 52'(sqrt_root) << sqrt_side.half;
        d_sum = 53'(s_val) + 53'(eps_reg);
        d_val = (d_sum == 53'h0) ? 53'd1 : d_sum;
        m_abs = sqrt_side.m[31] ? (~sqrt_side.m + 32'd1) : sqrt_side.m;
    end

    assign den_sum = {t2_pdhi_reg, 32'h0} + 86'(t2_pdlo_reg);

    always_comb
    begin
        t3_side_next.w   = t2_w_reg;
        t3_side_next.m   = t2_m_reg;
        t3_side_next.v   = t2_v_reg;
        t3_side_next.ovf = 86'(t2_mag_reg[63:2]) >= den_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t1_valid_reg <= sqrt_valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_d_reg    <= d_val;
            t1_mag_reg  <= 64'(lr_reg) * 64'(m_abs);
            t1_c1_reg   <= sqrt_side.c1;
            t1_w_reg    <= sqrt_side.w;
            t1_m_reg    <= sqrt_side.m;
            t1_v_reg    <= sqrt_side.v;

            t2_pdlo_reg <= 65'(t1_c1_reg) * 65'(t1_d_reg[31:0]);
            t2_pdhi_reg <= 54'(t1_c1_reg) * 54'(t1_d_reg[52:32]);
            t2_mag_reg  <= t1_mag_reg;
            t2_w_reg    <= t1_w_reg;
            t2_m_reg    <= t1_m_reg;
            t2_v_reg    <= t1_v_reg;

            t3_den_reg  <= den_sum;
            t3_mag_reg  <= t2_mag_reg;
            t3_side_reg <= t3_side_next;
        end
    end

    //------------------------------------------------------------------
    // u = lr * |m| * 2^32 / (c1 * d). The high part of the dividend is the
    // starting remainder, so only the 34 low quotient bits are formed; a
    // larger quotient is caught by the overflow flag.
    //------------------------------------------------------------------
    adam_div_pipe #(
        .DEN_W  (adam_pkg::DIV2_DEN_W),
        .Q_W    (adam_pkg::DIV2_Q_W),
        .SIDE_W (adam_pkg::DIV2_SIDE_W)
    ) u_div_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (t3_valid_reg),
        .in_rem    (86'(t3_mag_reg[63:2])),
        .in_num    ({t3_mag_reg[1:0], 32'h0}),
        .in_den    (t3_den_reg),
        .in_side   (t3_side_reg),
        .out_valid (div2_valid),
        .out_quot  (div2_quot),
        .out_side  (div2_out_side)
    );

    assign div2_side = div2_out_side;

    // The step is capped at 2^33 and moves the weight against the moment.
    always_comb
    begin
        if (div2_side.ovf || (div2_quot > 34'h2_0000_0000))
            step_u = 34'h2_0000_0000;
        else
            step_u = div2_quot;
        if (div2_side.m[31])
            w_upd = 36'(div2_side.w) + $signed({2'b00, step_u});
        else
            w_upd = 36'(div2_side.w) - $signed({2'b00, step_u});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_w_reg <= adam_pkg::sat_s32(w_upd);
            out_m_reg <= div2_side.m;
            out_v_reg <= div2_side.v;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_v_reg, out_m_reg, out_w_reg};

endmodule
